[rtl/bmm_pkg.sv]
package bmm_pkg;

	localparam logic [2:0] ACT_FETCH      = 3'd0;
	localparam logic [2:0] ACT_DATA_READ  = 3'd1;
	localparam logic [2:0] ACT_MEM_WRITE  = 3'd2;
	localparam logic [2:0] ACT_PORT_WRITE = 3'd3;
	localparam logic [2:0] ACT_PORT_READ  = 3'd4;

	localparam logic [15:0] TRAP_LOW     = 16'h3D00;
	localparam logic [15:0] WINDOW1_BASE = 16'h4000;

	localparam logic [15:0] SYS_PORT_VAL   = 16'h0000;
	localparam logic [15:0] SYS_PORT_MASK  = 16'h00FF;
	localparam logic [15:0] EXT_PORT_VAL   = 16'h00FD;
	localparam logic [15:0] EXT_PORT_MASK  = 16'h0023;
	localparam logic [15:0] MAIN_PORT_VAL  = 16'h7FFD;
	localparam logic [15:0] MAIN_PORT_MASK = 16'hFF23;
	localparam logic [15:0] ULA_PORT_VAL   = 16'h00FE;
	localparam logic [15:0] ULA_PORT_MASK  = 16'h0003;

	localparam logic [7:0] EXT_EXTRA_PAGING = 8'h1F;
	localparam logic [7:0] EXT_WINDOW_TWO   = 8'h78;
	localparam logic [7:0] EXT_STATUS_A     = 8'h7A;
	localparam logic [7:0] EXT_ROM_BANK     = 8'h7E;
	localparam logic [7:0] EXT_HIGH_PAGE    = 8'hDF;

	localparam logic [6:0] RAM_PAGE_WINDOW1 = 7'd5;
	localparam logic [6:0] WINDOW2_FLIP     = 7'd2;
	localparam logic [7:0] PORT_IDLE_DATA   = 8'hFF;

	function automatic logic port_hit(input logic [15:0] port, input logic [15:0] val,
		input logic [15:0] mask);
		return (port & mask) == (val & mask);
	endfunction

endpackage

[rtl/banked_memory_mapper_ports_core.sv]
// Paging and port block for a banked 8-bit CPU bus. Each item is one CPU access (opcode
// fetch, data read, memory write, port write or port read); it enters an input register,
// is decoded against the paging, system, border and beeper registers in shallow
// combinational logic and leaves through a result register. One item is taken every clock
// unless a held result is not taken (out_ready low). Register updates made by an item
// (port writes, disk-ROM trap, startup-code shifts) are seen by the very next item. The
// border, beeper and screen outputs reflect the state after that item.
module banked_memory_mapper_ports_core
	import bmm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  action,
	input  logic [15:0] address,
	input  logic [7:0]  data_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        is_ram,
	output logic [6:0]  page,
	output logic [13:0] offset,
	output logic        write_enable,
	output logic [7:0]  port_data,
	output logic        port_data_valid,
	output logic        cpu_reset_request,
	output logic [2:0]  border_colour,
	output logic        beeper_level,
	output logic        screen_page
);

	logic        valid_s1;
	logic [2:0]  action_s1;
	logic [15:0] address_s1;
	logic [7:0]  data_s1;

	logic        valid_s2;
	logic        is_ram_s2;
	logic [6:0]  page_s2;
	logic [13:0] offset_s2;
	logic        we_s2;
	logic [7:0]  pdata_s2;
	logic        pvalid_s2;
	logic        rst_s2;
	logic [2:0]  border_s2;
	logic        beeper_s2;
	logic        screen_s2;

	logic [7:0] main_paging_q, extra_paging_q, rom_bank_q, window_two_q;
	logic [7:0] high_page_q, system_control_q, code_shifter_q;
	logic       disk_rom_q;
	logic [2:0] border_q;
	logic       beeper_q;

	logic [7:0] main_paging_n, extra_paging_n, rom_bank_n, window_two_n;
	logic [7:0] high_page_n, system_control_n, code_shifter_n;
	logic       disk_rom_n;
	logic [2:0] border_n;
	logic       beeper_n;

	logic        is_ram_c, we_c, pvalid_c, rst_c;
	logic [6:0]  page_c;
	logic [13:0] offset_c;
	logic [7:0]  pdata_c;
	logic [6:0]  rom_sel_c;
	logic        advance;

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_comb begin
		main_paging_n    = main_paging_q;
		extra_paging_n   = extra_paging_q;
		rom_bank_n       = rom_bank_q;
		window_two_n     = window_two_q;
		high_page_n      = high_page_q;
		system_control_n = system_control_q;
		code_shifter_n   = code_shifter_q;
		disk_rom_n       = disk_rom_q;
		border_n         = border_q;
		beeper_n         = beeper_q;
		is_ram_c         = 1'b0;
		page_c           = '0;
		offset_c         = '0;
		we_c             = 1'b0;
		pdata_c          = PORT_IDLE_DATA;
		pvalid_c         = 1'b0;
		rst_c            = 1'b0;
		rom_sel_c        = '0;

		case (action_s1)
			ACT_FETCH, ACT_DATA_READ, ACT_MEM_WRITE: begin
				if (action_s1 == ACT_FETCH) begin
					if (!disk_rom_q && address_s1 >= TRAP_LOW && address_s1 < WINDOW1_BASE
						&& main_paging_q[4])
						disk_rom_n = 1'b1;
					else if (disk_rom_q && address_s1 >= WINDOW1_BASE)
						disk_rom_n = 1'b0;
				end
				offset_c = address_s1[13:0];
				we_c     = (action_s1 == ACT_MEM_WRITE) && (address_s1 >= WINDOW1_BASE);
				case (address_s1[15:14])
					2'd0: begin
						rom_sel_c = {2'b00, rom_bank_q[6:4], disk_rom_n, main_paging_q[4]};
						if (extra_paging_q[1])
							rom_sel_c = {2'b00, rom_bank_q[6:4], 2'b10};
						is_ram_c = 1'b0;
						page_c   = rom_sel_c;
						if (extra_paging_q[0]) begin
							is_ram_c = 1'b1;
							page_c   = '0;
						end
						if (extra_paging_q[2]) begin
							is_ram_c = 1'b0;
							page_c   = {2'b00, rom_bank_q[6:4], 2'b11};
						end
					end
					2'd1: begin
						is_ram_c = 1'b1;
						page_c   = RAM_PAGE_WINDOW1;
					end
					2'd2: begin
						is_ram_c = 1'b1;
						page_c   = window_two_q[6:0] ^ WINDOW2_FLIP;
					end
					default: begin
						is_ram_c = 1'b1;
						page_c   = {high_page_q[2:0], extra_paging_q[4], main_paging_q[2:0]};
					end
				endcase
			end
			ACT_PORT_WRITE: begin
				if (port_hit(address_s1, SYS_PORT_VAL, SYS_PORT_MASK)) begin
					system_control_n = data_s1;
					if (data_s1[3]) begin
						code_shifter_n = {5'b10000, data_s1[2:0]};
						rst_c          = !data_s1[4];
					end
				end
				if (port_hit(address_s1, EXT_PORT_VAL, EXT_PORT_MASK)) begin
					case (address_s1[15:8])
						EXT_EXTRA_PAGING: extra_paging_n = data_s1;
						EXT_WINDOW_TWO:   window_two_n   = data_s1;
						EXT_ROM_BANK:     rom_bank_n     = data_s1;
						EXT_HIGH_PAGE:    high_page_n    = data_s1;
						default: ;
					endcase
				end
				if (port_hit(address_s1, MAIN_PORT_VAL, MAIN_PORT_MASK) && !main_paging_q[5])
					main_paging_n = data_s1;
				if (port_hit(address_s1, ULA_PORT_VAL, ULA_PORT_MASK)) begin
					border_n = data_s1[2:0];
					beeper_n = data_s1[4];
				end
			end
			ACT_PORT_READ: begin
				if (port_hit(address_s1, EXT_PORT_VAL, EXT_PORT_MASK)) begin
					case (address_s1[15:8])
						EXT_STATUS_A: begin
							pdata_c  = {border_q[0], high_page_q[2:0], extra_paging_q[4],
								main_paging_q[2:0]};
							pvalid_c = 1'b1;
						end
						EXT_ROM_BANK: begin
							pdata_c  = {border_q[2], extra_paging_q[0], system_control_q[5],
								system_control_q[7], rom_bank_q[3], rom_bank_q[7],
								main_paging_q[3], main_paging_q[5]};
							pvalid_c = 1'b1;
						end
						EXT_WINDOW_TWO: begin
							pdata_c        = {border_q[1], window_two_q[6:1],
								window_two_q[0] | code_shifter_q[0]};
							code_shifter_n = {1'b0, code_shifter_q[7:1]};
							pvalid_c       = 1'b1;
						end
						default: ;
					endcase
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			action_s1  <= action;
			address_s1 <= address;
			data_s1    <= data_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2         <= 1'b0;
			main_paging_q    <= '0;
			extra_paging_q   <= '0;
			rom_bank_q       <= '0;
			window_two_q     <= '0;
			high_page_q      <= '0;
			system_control_q <= '0;
			code_shifter_q   <= '0;
			disk_rom_q       <= 1'b0;
			border_q         <= '0;
			beeper_q         <= 1'b0;
		end else begin
			if (advance) begin
				valid_s2         <= 1'b1;
				main_paging_q    <= main_paging_n;
				extra_paging_q   <= extra_paging_n;
				rom_bank_q       <= rom_bank_n;
				window_two_q     <= window_two_n;
				high_page_q      <= high_page_n;
				system_control_q <= system_control_n;
				code_shifter_q   <= code_shifter_n;
				disk_rom_q       <= disk_rom_n;
				border_q         <= border_n;
				beeper_q         <= beeper_n;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			is_ram_s2 <= is_ram_c;
			page_s2   <= page_c;
			offset_s2 <= offset_c;
			we_s2     <= we_c;
			pdata_s2  <= pdata_c;
			pvalid_s2 <= pvalid_c;
			rst_s2    <= rst_c;
			border_s2 <= border_n;
			beeper_s2 <= beeper_n;
			screen_s2 <= main_paging_n[3];
		end
	end

	assign out_valid         = valid_s2;
	assign is_ram            = is_ram_s2;
	assign page              = page_s2;
	assign offset            = offset_s2;
	assign write_enable      = we_s2;
	assign port_data         = pdata_s2;
	assign port_data_valid   = pvalid_s2;
	assign cpu_reset_request = rst_s2;
	assign border_colour     = border_s2;
	assign beeper_level      = beeper_s2;
	assign screen_page       = screen_s2;

endmodule
